### hw/rtl/utf8v_pkg.sv
package utf8v_pkg;

  // field widths
  localparam int unsigned ByteW      = 8;
  localparam int unsigned MaxBytesW  = 21;
  localparam int unsigned StatusW    = 2;
  localparam int unsigned CodeW      = 21;
  localparam int unsigned CountWidthDefault = 22;
  localparam int unsigned MaxItems   = 4;
  localparam int unsigned ItemCntW   = 3;

  localparam logic [MaxBytesW-1:0] MaxBytesReset = 21'd1048576;

  // byte codes
  localparam logic [ByteW-1:0] BOM_B0  = 8'hEF;
  localparam logic [ByteW-1:0] BOM_B1  = 8'hBB;
  localparam logic [ByteW-1:0] BOM_B2  = 8'hBF;
  localparam logic [ByteW-1:0] CHAR_LF = 8'h0A;
  localparam logic [ByteW-1:0] CHAR_CR = 8'h0D;
  localparam logic [ByteW-1:0] CHAR_NUL = 8'h00;

  // code point limits
  localparam logic [CodeW-1:0] CP_MIN2   = 21'h80;
  localparam logic [CodeW-1:0] CP_MIN3   = 21'h800;
  localparam logic [CodeW-1:0] CP_MIN4   = 21'h10000;
  localparam logic [CodeW-1:0] CP_MAX    = 21'h10FFFF;
  localparam logic [CodeW-1:0] CP_SUR_LO = 21'hD800;
  localparam logic [CodeW-1:0] CP_SUR_HI = 21'hDFFF;

  // status codes
  localparam logic [StatusW-1:0] STATUS_OK       = 2'd0;
  localparam logic [StatusW-1:0] STATUS_TOO_LONG = 2'd1;
  localparam logic [StatusW-1:0] STATUS_BAD_UTF8 = 2'd2;
  localparam logic [StatusW-1:0] STATUS_NUL      = 2'd3;

  // decoder and line-end state of one text
  typedef struct packed {
    logic [1:0]       cont_left;
    logic [1:0]       seq_len;
    logic [CodeW-1:0] code_acc;
    logic             pending_cr;
    logic             bad_utf8;
    logic             nul_seen;
  } text_st_t;

  typedef struct packed {
    text_st_t         st;
    logic             emit;
    logic [ByteW-1:0] obyte;
  } pass_res_t;

  typedef struct packed {
    logic [ByteW-1:0]   out_byte;
    logic               is_status;
    logic [StatusW-1:0] status;
    logic               end_of_run;
  } item_t;

  // result items caused by one input
  typedef struct packed {
    logic [ItemCntW-1:0]    n;
    item_t [MaxItems-1:0]   item;
  } batch_t;

  // sequence end check: overlong, surrogate, out of range
  function automatic logic seq_is_bad(input logic [1:0] seq_len, input logic [CodeW-1:0] cp);
    logic bad;
    bad = ((seq_len == 2'd1) && (cp < CP_MIN2)) ||
          ((seq_len == 2'd2) && (cp < CP_MIN3)) ||
          ((seq_len == 2'd3) && (cp < CP_MIN4)) ||
          (cp > CP_MAX) ||
          ((cp >= CP_SUR_LO) && (cp <= CP_SUR_HI));
    return bad;
  endfunction

  // decode, check and normalize one byte after mark removal
  function automatic pass_res_t pass_byte(input text_st_t s, input logic [ByteW-1:0] b);
    pass_res_t r;
    logic      lead;
    r.st    = s;
    r.emit  = 1'b0;
    r.obyte = b;
    lead    = 1'b1;
    // continuation handling
    if (s.cont_left != 2'd0) begin
      if (b[7:6] == 2'b10) begin
        r.st.code_acc  = {s.code_acc[CodeW-7:0], b[5:0]};
        r.st.cont_left = s.cont_left - 2'd1;
        if (r.st.cont_left == 2'd0 && seq_is_bad(s.seq_len, r.st.code_acc)) begin
          r.st.bad_utf8 = 1'b1;
        end
        lead = 1'b0;
      end else begin
        r.st.bad_utf8  = 1'b1;
        r.st.cont_left = 2'd0;
      end
    end
    // lead byte handling
    if (lead && b[7]) begin
      if (b[7:5] == 3'b110) begin
        r.st.seq_len   = 2'd1;
        r.st.cont_left = 2'd1;
        r.st.code_acc  = {16'd0, b[4:0]};
      end else if (b[7:4] == 4'b1110) begin
        r.st.seq_len   = 2'd2;
        r.st.cont_left = 2'd2;
        r.st.code_acc  = {17'd0, b[3:0]};
      end else if (b[7:3] == 5'b11110) begin
        r.st.seq_len   = 2'd3;
        r.st.cont_left = 2'd3;
        r.st.code_acc  = {18'd0, b[2:0]};
      end else begin
        r.st.bad_utf8 = 1'b1;
      end
    end
    if (b == CHAR_NUL) begin
      r.st.nul_seen = 1'b1;
    end
    // line-end normalization
    if (b == CHAR_LF && s.pending_cr) begin
      r.st.pending_cr = 1'b0;
    end else if (b == CHAR_CR) begin
      r.st.pending_cr = 1'b1;
      r.emit          = 1'b1;
      r.obyte         = CHAR_LF;
    end else begin
      r.st.pending_cr = 1'b0;
      r.emit          = 1'b1;
    end
    return r;
  endfunction

endpackage

### hw/rtl/utf8_validate_bom_strip_crlf_normalize_unit.sv
// throughput: one byte per cycle while the output is ready and each byte gives at most
// one result; a byte that releases held mark bytes or closes a text gives up to four,
// drained one per cycle while the output is ready from the result buffer, which holds
// back the input register meanwhile
// reset: asynchronous active low; clears text state, buffers and sets max_bytes to 1048576
module utf8_validate_bom_strip_crlf_normalize_unit #(
  parameter int unsigned COUNT_WIDTH = utf8v_pkg::CountWidthDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // config write
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [utf8v_pkg::MaxBytesW-1:0] cfg_data_i,
  // input stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,  // [7:0] data_byte
  input  logic                            s_axis_tlast,
  // output stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [15:0]                     m_axis_tdata,  // [7:0] out_byte, [9:8] status
  output logic                            m_axis_tuser,  // [0] is_status
  output logic                            m_axis_tlast
);
  import utf8v_pkg::*;

  logic [MaxBytesW-1:0] max_bytes_q;
  logic                 in_valid_q;
  logic [ByteW-1:0]     in_byte_q;
  logic                 in_last_q;
  logic                 step;
  logic                 free;
  batch_t               batch;
  item_t                head;

  // config register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_bytes_q <= MaxBytesReset;
    end else if (cfg_valid_i) begin
      max_bytes_q <= cfg_data_i;
    end
  end

  // input register
  assign step          = in_valid_q && free;
  assign s_axis_tready = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  utf8v_core #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .byte_i     (in_byte_q),
    .last_i     (in_last_q),
    .max_bytes_i(max_bytes_q),
    .batch_o    (batch)
  );

  utf8v_outbuf u_outbuf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (step),
    .batch_i(batch),
    .pop_i  (m_axis_tready),
    .free_o (free),
    .valid_o(m_axis_tvalid),
    .head_o (head)
  );

  // output packing
  assign m_axis_tdata = {6'd0, head.status, head.out_byte};
  assign m_axis_tuser = head.is_status;
  assign m_axis_tlast = head.end_of_run;

  // a loaded nonempty batch shows up at the output next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && (batch.n != '0) |=> m_axis_tvalid)
    else $error("loaded results not presented");

  // a status transaction always closes its run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("status item without end of run");

  // byte transactions carry a zero status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> (m_axis_tdata[9:8] == STATUS_OK))
    else $error("byte item with nonzero status");

  // the result buffer never takes a batch more than four items long
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |-> (batch.n <= ItemCntW'(MaxItems)))
    else $error("batch overflow");

endmodule

### hw/rtl/utf8v_core.sv
module utf8v_core #(
  parameter int unsigned COUNT_WIDTH = utf8v_pkg::CountWidthDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              step_i,
  input  logic [utf8v_pkg::ByteW-1:0]       byte_i,
  input  logic                              last_i,
  input  logic [utf8v_pkg::MaxBytesW-1:0]   max_bytes_i,
  output utf8v_pkg::batch_t                 batch_o
);
  import utf8v_pkg::*;

  localparam int unsigned CmpW = (COUNT_WIDTH > MaxBytesW) ? COUNT_WIDTH : MaxBytesW;

  typedef enum logic [1:0] {
    BomStart,
    BomEf,
    BomEfBb,
    BomDone
  } bom_e;

  bom_e                   bom_q, bom_d;
  logic [COUNT_WIDTH-1:0] count_q, count_d;
  logic                   too_long_q, too_long_d;
  text_st_t               st_q, st_d;

  logic [COUNT_WIDTH-1:0] count_inc;
  pass_res_t              p_ef, p_bb, p_cur;
  text_st_t               st_a, st_b;
  batch_t                 batch;
  logic [ItemCntW-1:0]    k;
  logic [StatusW-1:0]     code;
  logic                   bad_end;

  // saturating length count and limit check
  assign count_inc = (count_q != '1) ? count_q + COUNT_WIDTH'(1) : count_q;
  assign too_long_d = too_long_q |
      (CmpW'(count_inc) > CmpW'(max_bytes_i));

  // released mark bytes, then the current byte
  assign p_ef  = pass_byte(st_q, BOM_B0);
  assign st_a  = (bom_q == BomEf || bom_q == BomEfBb) ? p_ef.st : st_q;
  assign p_bb  = pass_byte(st_a, BOM_B1);
  assign st_b  = (bom_q == BomEfBb) ? p_bb.st : st_a;
  assign p_cur = pass_byte(st_b, byte_i);

  // state update and result list
  always_comb begin
    batch   = '0;
    k       = '0;
    bom_d   = bom_q;
    st_d    = st_q;
    code    = STATUS_OK;
    bad_end = 1'b0;
    count_d = count_inc;
    if (bom_q == BomStart && byte_i == BOM_B0 && !last_i) begin
      bom_d = BomEf;
    end else if (bom_q == BomEf && byte_i == BOM_B1 && !last_i) begin
      bom_d = BomEfBb;
    end else if (bom_q == BomEfBb && byte_i == BOM_B2) begin
      bom_d = BomDone;
    end else begin
      if (bom_q == BomEf || bom_q == BomEfBb) begin
        batch.item[k[1:0]].out_byte = p_ef.obyte;
        k = k + ItemCntW'(p_ef.emit);
      end
      if (bom_q == BomEfBb) begin
        batch.item[k[1:0]].out_byte = p_bb.obyte;
        k = k + ItemCntW'(p_bb.emit);
      end
      if (p_cur.emit) begin
        batch.item[k[1:0]].out_byte = p_cur.obyte;
        k = k + ItemCntW'(1);
      end
      bom_d = BomDone;
      st_d  = p_cur.st;
    end
    // status item at end of text
    if (last_i) begin
      bad_end = st_d.bad_utf8 || (st_d.cont_left != 2'd0);
      if (too_long_d) begin
        code = STATUS_TOO_LONG;
      end else if (bad_end) begin
        code = STATUS_BAD_UTF8;
      end else if (st_d.nul_seen) begin
        code = STATUS_NUL;
      end
      batch.item[k[1:0]].is_status = 1'b1;
      batch.item[k[1:0]].status    = code;
      k = k + ItemCntW'(1);
    end
    if (k != '0) begin
      batch.item[k[1:0] - 2'd1].end_of_run = 1'b1;
    end
    batch.n = k;
  end

  assign batch_o = batch;

  // text state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bom_q      <= BomStart;
      count_q    <= '0;
      too_long_q <= 1'b0;
      st_q       <= '0;
    end else if (step_i) begin
      if (last_i) begin
        bom_q      <= BomStart;
        count_q    <= '0;
        too_long_q <= 1'b0;
        st_q       <= '0;
      end else begin
        bom_q      <= bom_d;
        count_q    <= count_d;
        too_long_q <= too_long_d;
        st_q       <= st_d;
      end
    end
  end

endmodule

### hw/rtl/utf8v_outbuf.sv
module utf8v_outbuf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  utf8v_pkg::batch_t batch_i,
  input  logic              pop_i,
  output logic              free_o,
  output logic              valid_o,
  output utf8v_pkg::item_t  head_o
);
  import utf8v_pkg::*;

  item_t [MaxItems-1:0] items_q, items_d;
  logic [ItemCntW-1:0]  cnt_q, cnt_d;
  logic                 pop;

  assign pop     = pop_i && (cnt_q != '0);
  assign free_o  = (cnt_q == '0) || ((cnt_q == ItemCntW'(1)) && pop);
  assign valid_o = (cnt_q != '0);
  assign head_o  = items_q[0];

  // drain by shifting toward the head, refill with a whole batch
  always_comb begin
    items_d = items_q;
    cnt_d   = cnt_q;
    if (pop) begin
      for (int i = 0; i < MaxItems - 1; i++) begin
        items_d[i] = items_q[i+1];
      end
      cnt_d = cnt_q - ItemCntW'(1);
    end
    if (load_i) begin
      items_d = batch_i.item;
      cnt_d   = batch_i.n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    items_q <= items_d;
  end

endmodule
